>>> design/ilb_pkg.sv
// ----------------------------------------------------------------------------
// ilb_pkg: shared types and constants for the indexed list buffer
// Operation codes, result status codes, the sequencer states and the default
// list capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package ilb_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_GET      = 3'd0,
    OP_ADD_HEAD = 3'd1,
    OP_ADD_TAIL = 3'd2,
    OP_INSERT   = 3'd3,
    OP_DELETE   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_INS,
    S_PUT,
    S_DEL,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

>>> design/indexed_list_buffer_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer_unit: ordered list of signed words with indexed access
// Get, add at head or tail, insert before a position, delete at a position
// and clear, over a single-port-write list memory with a sequenced shifter.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_ready is high only while the sequencer
// is idle, and a finished result waits in the output register so the next
// request can be taken meanwhile. Insert before position p and delete at p
// take longer the further p lies from the end of the list, because entries
// move through the list memory one per cycle (one read and one write port),
// so the longest request is an insert at the head of a list one short of
// CAPACITY entries.
`default_nettype none

module indexed_list_buffer_unit #(
  parameter int unsigned CAPACITY = ilb_pkg::CAPACITY_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [ilb_pkg::OP_W-1:0]             in_operation,
  input  wire logic [ilb_pkg::POS_W-1:0]            in_position,
  input  wire logic signed [ilb_pkg::DATA_W-1:0]    in_item_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [ilb_pkg::DATA_W-1:0]         out_read_value,
  output logic [ilb_pkg::STATUS_W-1:0]              out_status
);
  import ilb_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  // list storage, no reset: only entries below the length are ever used
  logic [DATA_W-1:0] mem [CAPACITY];

  state_t             state_r, state_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [LW-1:0]      tgt_r, tgt_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]      wr_addr_r, wr_addr_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic [DATA_W-1:0]  res_value_r, res_value_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_value_r;
  status_t            out_status_r;

  logic               in_acc;
  logic               out_load;
  logic [CW-1:0]      pos_w, len_w;
  logic               pos_lt_len, pos_le_len, is_full;
  logic [LW-1:0]      idx_dec, idx_inc;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [DATA_W-1:0]  mem_wdata;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_load   = (state_r == S_RESP) && (!out_valid_r || out_ready);

  assign pos_w      = CW'(in_position);
  assign len_w      = CW'(len_r);
  assign pos_lt_len = pos_w < len_w;
  assign pos_le_len = pos_w <= len_w;
  assign is_full    = (len_r == LW'(CAPACITY));
  assign idx_dec    = idx_r - LW'(1);
  assign idx_inc    = idx_r + LW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_operation))
            OP_GET:      state_nxt = pos_lt_len ? S_GET : S_RESP;
            OP_ADD_HEAD,
            OP_ADD_TAIL: state_nxt = is_full ? S_RESP : S_INS;
            OP_INSERT:   state_nxt = (pos_le_len && !is_full) ? S_INS : S_RESP;
            OP_DELETE:   state_nxt = pos_lt_len ? S_DEL : S_RESP;
            default:     state_nxt = S_RESP;
          endcase
        end
      end
      S_GET:  state_nxt = S_RESP;
      S_INS:  state_nxt = (idx_r > tgt_r) ? S_INS : S_PUT;
      S_PUT:  state_nxt = S_RESP;
      S_DEL:  state_nxt = (idx_inc < len_r) ? S_DEL : S_RESP;
      S_RESP: state_nxt = out_load ? S_IDLE : S_RESP;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    tgt_nxt        = tgt_r;
    val_nxt        = val_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mem_raddr      = idx_r[AW-1:0];
    mem_we         = wr_pend_r;
    mem_waddr      = wr_addr_r;
    mem_wdata      = rd_data_r;
    case (state_r)
      S_IDLE: begin
        mem_raddr = AW'(in_position);
        if (in_acc) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_DONE;
          idx_nxt        = len_r;
          val_nxt        = in_item_value;
          case (op_t'(in_operation))
            OP_GET: begin
              if (!pos_lt_len) begin
                res_value_nxt  = '1;
                res_status_nxt = ST_INVALID;
              end
            end
            OP_ADD_HEAD: begin
              tgt_nxt = '0;
              if (is_full) res_status_nxt = ST_FULL;
            end
            OP_ADD_TAIL: begin
              tgt_nxt = len_r;
              if (is_full) res_status_nxt = ST_FULL;
            end
            OP_INSERT: begin
              tgt_nxt = LW'(in_position);
              if (!pos_le_len) res_status_nxt = ST_INVALID;
              else if (is_full) res_status_nxt = ST_FULL;
            end
            OP_DELETE: begin
              idx_nxt = LW'(in_position);
              if (!pos_lt_len) res_status_nxt = ST_INVALID;
            end
            OP_CLEAR: begin
              len_nxt = '0;
            end
            default: begin
              res_status_nxt = ST_INVALID;
            end
          endcase
        end
      end
      S_GET: begin
        res_value_nxt = rd_data_r;
      end
      S_INS: begin
        // read entry below, write it one place up on the next cycle
        mem_raddr = idx_dec[AW-1:0];
        if (idx_r > tgt_r) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_dec;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r[AW-1:0];
        mem_wdata = val_r;
        len_nxt   = len_r + LW'(1);
      end
      S_DEL: begin
        mem_raddr = idx_inc[AW-1:0];
        if (idx_inc < len_r) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_inc;
        end else begin
          len_nxt = len_r - LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      wr_pend_r <= wr_pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    tgt_r        <= tgt_nxt;
    val_r        <= val_nxt;
    wr_addr_r    <= wr_addr_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(CAPACITY))
    else $error("list length above capacity");

  a_ins_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (idx_r >= tgt_r && idx_r < LW'(CAPACITY)))
    else $error("insert shift index out of range");

  a_del_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL) |-> (idx_r < len_r))
    else $error("delete shift index out of range");

  a_put_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |=> (len_r == $past(len_r) + LW'(1)))
    else $error("insert did not grow the list");

  a_pend_owner: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_INS || state_r == S_DEL || state_r == S_PUT
                   || state_r == S_RESP))
    else $error("shift write pending outside a shift");

endmodule

`default_nettype wire

>>> dv/indexed_list_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_buffer_unit_tb: request-level check of the indexed list buffer
// Directed requests hit the empty list, both ends, the position limits and
// the unused operation codes. Random traffic then swings the list between
// empty and full. Every accepted request is run through a behavioural copy
// of the list, and each result is compared in order against that copy.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_buffer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilb_pkg::*;

  localparam int unsigned CAP        = CAPACITY_DEF;
  localparam int unsigned HALF_CLK   = 5;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned PRINT_CAP  = 40;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef enum int {MODE_FILL, MODE_MIXED, MODE_DRAIN} traffic_mode_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
  } list_result_t;

  // shadow copy of the list plus the queue of results still owed
  class list_tracker;
    logic signed [DATA_W-1:0] slots [CAP];
    int unsigned              fill;
    list_result_t             owed [$];
    int unsigned              errors;
    int unsigned              seen;

    function new();
      fill   = 0;
      errors = 0;
      seen   = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < PRINT_CAP)
        $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function status_t place(int unsigned pos, logic signed [DATA_W-1:0] value);
      if (fill >= CAP)
        return ST_FULL;
      for (int unsigned i = fill; i > pos; i--)
        slots[i] = slots[i-1];
      slots[pos] = value;
      fill++;
      return ST_DONE;
    endfunction

    function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] value);
      list_result_t r;
      r.op         = op;
      r.read_value = '0;
      r.status     = ST_DONE;
      case (op)
        OP_GET: begin
          if (pos < fill) begin
            r.read_value = slots[pos];
          end else begin
            r.read_value = -1;
            r.status     = ST_INVALID;
          end
        end
        OP_ADD_HEAD: r.status = place(0, value);
        OP_ADD_TAIL: r.status = place(fill, value);
        OP_INSERT: begin
          // position check wins over the full check
          if (pos > fill)
            r.status = ST_INVALID;
          else
            r.status = place(pos, value);
        end
        OP_DELETE: begin
          if (pos < fill) begin
            for (int unsigned i = pos; i + 1 < fill; i++)
              slots[i] = slots[i+1];
            fill--;
          end else begin
            r.status = ST_INVALID;
          end
        end
        OP_CLEAR: fill = 0;
        default: r.status = ST_INVALID;
      endcase
      owed.push_back(r);
    endfunction

    task check_result(logic signed [DATA_W-1:0] value, logic [STATUS_W-1:0] status);
      list_result_t e;
      seen++;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing owed: value %0d status %0d",
                                  seen, value, status));
        return;
      end
      e = owed.pop_front();
      if (value !== e.read_value)
        report_mismatch($sformatf("result %0d op %0d: value %0d, want %0d",
                                  seen, e.op, value, e.read_value));
      if (status !== e.status)
        report_mismatch($sformatf("result %0d op %0d: status %0d, want %0d",
                                  seen, e.op, status, e.status));
    endtask
  endclass

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation   = OP_GET;
  logic [POS_W-1:0]         in_position    = '0;
  logic signed [DATA_W-1:0] in_item_value  = '0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic signed [DATA_W-1:0] out_read_value;
  logic [STATUS_W-1:0]      out_status;

  int unsigned   in_idle_pct  = 21;
  int unsigned   out_idle_pct = 49;
  int unsigned   cycles       = 0;
  list_tracker   book         = new();

  // weights per operation code, spare codes last
  int unsigned mix_weight [3][8] = '{
    '{ 5, 30, 30, 32,  2, 0, 1, 0},
    '{30, 10, 10, 15, 28, 3, 2, 2},
    '{18,  4,  4,  5, 64, 3, 1, 1}
  };

  indexed_list_buffer_unit #(.CAPACITY(CAP)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_position    (in_position),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

  always #(HALF_CLK) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result(out_read_value, out_status);
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_position   <= pos;
    in_item_value <= value;
    do @(posedge clk); while (!in_ready);
    book.apply_request(op, pos, value);
    @(negedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_operation(traffic_mode_t mode);
    int unsigned r;
    int unsigned acc;
    r   = $urandom_range(99);
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      acc += mix_weight[mode][k];
      if (r < acc)
        return k[OP_W-1:0];
    end
    return OP_GET;
  endfunction

  // mostly positions within or just past the list, some anywhere
  function automatic logic [POS_W-1:0] pick_position(int unsigned len);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)
      return POS_W'($urandom());
    if (r < 16)
      return len[POS_W-1:0];
    return POS_W'($urandom_range(len));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_directed();
    send_request(OP_GET,      16'd0,      32'sd5);
    send_request(OP_DELETE,   16'd0,      32'sd0);
    send_request(OP_INSERT,   16'd1,      32'sd9);
    send_request(OP_CLEAR,    16'd0,      32'sd0);
    send_request(OP_ADD_TAIL, 16'd0,      32'sh7FFF_FFFF);
    send_request(OP_ADD_HEAD, 16'd0,      32'sh8000_0000);
    send_request(OP_INSERT,   16'd2,      32'sd0);
    send_request(OP_INSERT,   16'd1,      -32'sd1);
    send_request(OP_ADD_TAIL, 16'd0,      32'shA5A5_5A5A);
    send_request(OP_GET,      16'd0,      32'sd0);
    send_request(OP_GET,      16'd4,      32'sd0);
    send_request(OP_GET,      16'd5,      32'sd0);
    send_request(OP_GET,      16'hFFFF,   32'sd0);
    send_request(OP_INSERT,   16'hFFFF,   32'sd1);
    send_request(OP_DELETE,   16'hFFFF,   32'sd0);
    send_request(OP_DELETE,   16'd0,      32'sd0);
    send_request(OP_DELETE,   16'd3,      32'sd0);
    send_request(OP_DELETE,   16'd1,      32'sd0);
    send_request(OP_SPARE_A,  16'hFFFF,   -32'sd1);
    send_request(OP_SPARE_B,  16'd0,      32'sh1234_5678);
    send_request(OP_GET,      16'd0,      32'sd0);
    send_request(OP_CLEAR,    16'hFFFF,   32'sd7);
    send_request(OP_GET,      16'd0,      32'sd0);
  endtask

  task automatic run_traffic(traffic_mode_t mode, int unsigned n);
    logic [OP_W-1:0] op;
    repeat (n) begin
      op = pick_operation(mode);
      send_request(op, pick_position(book.fill), pick_value());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          in_idle_pct  = 21;
          out_idle_pct = 49;
        end
        1: begin
          in_idle_pct  = 49;
          out_idle_pct = 21;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      if (phase == 0)
        run_directed();
      repeat (2) begin
        run_traffic(MODE_FILL, 85);
        run_traffic(MODE_MIXED, 40);
        run_traffic(MODE_DRAIN, 85);
      end
    end
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (book.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/ilb_pkg.sv
design/indexed_list_buffer_unit.sv
dv/indexed_list_buffer_unit_tb.sv
